@@ hdl/trs_pkg.sv @@
// trs_pkg: shared sizes, command codes, table entry and port group types
// and the per-entry update function of the task ready scheduler
// no dependencies
`default_nettype none

package trs_pkg;

   // table geometry
   localparam int NUM_TASKS  = 8;
   localparam int DELAY_BITS = 16;
   localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // beat field widths
   localparam int CMD_W    = 3;
   localparam int TASK_W   = 3;
   localparam int AMOUNT_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 3'd0,
      CMD_DELAY   = 3'd1,
      CMD_FINISH  = 3'd2,
      CMD_YIELD   = 3'd3,
      CMD_RESTART = 3'd4,
      CMD_TICK    = 3'd5
   } cmd_type;

   typedef struct packed {
      logic                  done;
      logic [DELAY_BITS-1:0] delay;
   } entry_type;

   // access group from the sequencer to the task table
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } tbl_req_type;

   // new contents of table entry idx after one command
   function automatic entry_type entry_update(
      input logic [CMD_W-1:0]    cmd,
      input logic [TASK_W-1:0]   tid,
      input logic [AMOUNT_W-1:0] amt,
      input logic [IDX_W-1:0]    idx,
      input entry_type           cur
   );
      entry_type           nxt;
      logic                hit;
      logic [DELAY_BITS:0] sum;
      nxt = cur;
      hit = (int'(idx) == int'(tid));
      sum = {1'b0, cur.delay} + (DELAY_BITS+1)'(amt);
      case (cmd)
         CMD_LOAD: begin
            if (hit) begin
               nxt = '0;
            end
         end
         CMD_DELAY: begin
            if (hit) begin
               nxt.delay = sum[DELAY_BITS] ? '1 : sum[DELAY_BITS-1:0];
            end
         end
         CMD_FINISH: begin
            if (hit) begin
               nxt.done = 1'b1;
            end
         end
         CMD_RESTART: begin
            nxt = '0;
         end
         CMD_TICK: begin
            if (cur.delay != '0) begin
               nxt.delay = cur.delay - DELAY_BITS'(1);
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

@@ hdl/trs_req_if.sv @@
// trs_req_if: command beat channel of the task ready scheduler
// depends on trs_pkg for field widths
`default_nettype none

interface trs_req_if;
   logic                          valid;
   logic                          ready;
   logic [trs_pkg::CMD_W-1:0]    cmd;
   logic [trs_pkg::TASK_W-1:0]   task_id;
   logic [trs_pkg::AMOUNT_W-1:0] delay_amount;

   modport source (output valid, output cmd, output task_id, output delay_amount,
                   input ready);
   modport sink   (input valid, input cmd, input task_id, input delay_amount,
                   output ready);
endinterface

`default_nettype wire

@@ hdl/trs_rsp_if.sv @@
// trs_rsp_if: result beat channel of the task ready scheduler
// depends on trs_pkg for field widths
`default_nettype none

interface trs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [trs_pkg::TASK_W-1:0] next_task;
   logic                        next_valid;
   logic                        earlier_finished;

   modport source (output valid, output next_task, output next_valid,
                   output earlier_finished, input ready);
   modport sink   (input valid, input next_task, input next_valid,
                   input earlier_finished, output ready);
endinterface

`default_nettype wire

@@ hdl/trs_table.sv @@
// trs_table: task table memory, one read and one write port, registered read
// per-entry valid bits make unwritten entries read as zero after reset
// depends on trs_pkg
`default_nettype none

module trs_table (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire trs_pkg::tbl_req_type tbl_req,
   output trs_pkg::entry_type        rd_data
);

   trs_pkg::entry_type               mem [trs_pkg::NUM_TASKS];
   logic [trs_pkg::NUM_TASKS-1:0]    vld_ff;
   logic [trs_pkg::NUM_TASKS-1:0]    vld_in;
   trs_pkg::entry_type               rd_q_ff;
   logic                             hit_ff;

   // valid bits: set on write, all cleared by reset
   always_comb begin
      vld_in = vld_ff;
      if (tbl_req.wr_en) begin
         vld_in[tbl_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // memory array, write then registered read
   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_q_ff <= mem[tbl_req.rd_addr];
         hit_ff  <= vld_ff[tbl_req.rd_addr];
      end
   end

   assign rd_data = hit_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

@@ hdl/trs_ctrl.sv @@
// trs_ctrl: sweep sequencer, per-entry read-modify-write, ready scan and
// result register of the task ready scheduler
// depends on trs_pkg, trs_req_if, trs_rsp_if
`default_nettype none

module trs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   trs_req_if.sink                   req_chan,
   trs_rsp_if.source                 rsp_chan,
   output trs_pkg::tbl_req_type      tbl_req,
   input  wire trs_pkg::entry_type   rd_data
);

   localparam logic [trs_pkg::IDX_W-1:0] LAST_IDX = trs_pkg::IDX_W'(trs_pkg::NUM_TASKS - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_HOLD  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic                             issue_ff, issue_in;
   logic [trs_pkg::IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                             s1_vld_ff, s1_vld_in;
   logic [trs_pkg::IDX_W-1:0]        s1_idx_ff, s1_idx_in;
   logic [trs_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [trs_pkg::TASK_W-1:0]       tid_ff, tid_in;
   logic [trs_pkg::AMOUNT_W-1:0]     amt_ff, amt_in;
   logic [trs_pkg::IDX_W-1:0]        pick_ff, pick_in;
   logic                             found_ff, found_in;
   logic                             alld_ff, alld_in;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic [trs_pkg::TASK_W-1:0]       rsp_task_ff, rsp_task_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic                             rsp_alld_ff, rsp_alld_in;
   logic                             accept;
   logic                             take;
   logic                             out_free;
   trs_pkg::entry_type               new_entry;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign take           = rsp_vld_ff && rsp_chan.ready;
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;

   assign new_entry = trs_pkg::entry_update(cmd_ff, tid_ff, amt_ff, s1_idx_ff, rd_data);

   // sequencer, write-back and scan
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      rd_idx_in    = rd_idx_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = rd_idx_ff;
      cmd_in       = cmd_ff;
      tid_in       = tid_ff;
      amt_in       = amt_ff;
      pick_in      = pick_ff;
      found_in     = found_ff;
      alld_in      = alld_ff;
      rsp_vld_in   = rsp_vld_ff && !take;
      rsp_task_in  = rsp_task_ff;
      rsp_found_in = rsp_found_ff;
      rsp_alld_in  = rsp_alld_ff;
      tbl_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_chan.cmd;
               tid_in    = req_chan.task_id;
               amt_in    = req_chan.delay_amount;
               rd_idx_in = '0;
               issue_in  = 1'b1;
               pick_in   = '0;
               found_in  = 1'b0;
               alld_in   = 1'b1;
               state_in  = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // read side: one entry per cycle
            if (issue_ff) begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = rd_idx_ff;
               s1_vld_in       = 1'b1;
               if (rd_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + trs_pkg::IDX_W'(1);
               end
            end
            // write-back side and scan on the updated entry
            if (s1_vld_ff) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = s1_idx_ff;
               tbl_req.wr_data = new_entry;
               if (!found_ff && !new_entry.done && (new_entry.delay == '0)) begin
                  pick_in  = s1_idx_ff;
                  found_in = 1'b1;
               end
               if ((int'(s1_idx_ff) < int'(tid_ff)) && !new_entry.done) begin
                  alld_in = 1'b0;
               end
               if (s1_idx_ff == LAST_IDX) begin
                  if (out_free) begin
                     rsp_vld_in   = 1'b1;
                     rsp_task_in  = trs_pkg::TASK_W'(pick_in);
                     rsp_found_in = found_in;
                     rsp_alld_in  = alld_in;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_HOLD;
                  end
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_task_in  = trs_pkg::TASK_W'(pick_ff);
               rsp_found_in = found_ff;
               rsp_alld_in  = alld_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issue_ff   <= 1'b0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      s1_idx_ff    <= s1_idx_in;
      cmd_ff       <= cmd_in;
      tid_ff       <= tid_in;
      amt_ff       <= amt_in;
      pick_ff      <= pick_in;
      found_ff     <= found_in;
      alld_ff      <= alld_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_found_ff <= rsp_found_in;
      rsp_alld_ff  <= rsp_alld_in;
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.next_task        = rsp_task_ff;
   assign rsp_chan.next_valid       = rsp_found_ff;
   assign rsp_chan.earlier_finished = rsp_alld_ff;

endmodule

`default_nettype wire

@@ hdl/task_ready_scheduler.sv @@
// task_ready_scheduler: fixed-priority task scheduler with tick delays
// an accepted command closes the input until its result beat is registered,
// held back by the sweep that reads, updates and writes back every table entry
// through the table's read and write ports, and by a full result register
// reset: synchronous; clears all delays and finished flags via valid bits
// depends on trs_pkg, trs_req_if, trs_rsp_if, trs_table, trs_ctrl
`default_nettype none

module task_ready_scheduler (
   input  wire logic clock,
   input  wire logic reset,
   trs_req_if.sink   req_chan,
   trs_rsp_if.source rsp_chan
);

   trs_pkg::tbl_req_type tbl_req;
   trs_pkg::entry_type   rd_data;

   // sweep sequencer and result register
   trs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .tbl_req  (tbl_req),
      .rd_data  (rd_data)
   );

   // task table
   trs_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

   // read and write never hit the same entry in one cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(tbl_req.rd_en && tbl_req.wr_en && (tbl_req.rd_addr == tbl_req.wr_addr)))
      else $error("table read and write collide on one entry");

   // table is only touched while a command is in progress
   a_busy_access: assert property (@(posedge clock) disable iff (reset)
      (tbl_req.rd_en || tbl_req.wr_en) |-> !req_chan.ready)
      else $error("table accessed while idle");

   // an accepted command closes the input until its sweep ends
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("command beat accepted during a sweep");

endmodule

`default_nettype wire

@@ dv/task_ready_scheduler_test.sv @@
`timescale 1ns / 1ps
// task_ready_scheduler_test: self-checking bench for the task ready scheduler,
// predicting each result beat from its own copy of the task table
// depends on trs_pkg, trs_req_if, trs_rsp_if and task_ready_scheduler
`default_nettype none

module task_ready_scheduler_test;

   // command codes the block does not define, treated as yield
   localparam logic [trs_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [trs_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam logic [trs_pkg::DELAY_BITS-1:0] DELAY_MAX = '1;
   localparam int DRAIN_CYCLES = 3 * (trs_pkg::NUM_TASKS + 2);

   typedef struct {
      logic [trs_pkg::TASK_W-1:0] next_task;
      logic                       next_valid;
      logic                       earlier_finished;
   } sched_result_type;

   logic clock;
   logic reset;

   trs_req_if req_chan ();
   trs_rsp_if rsp_chan ();

   // predicted task table
   logic [trs_pkg::DELAY_BITS-1:0] task_delay [trs_pkg::NUM_TASKS];
   logic                           task_done  [trs_pkg::NUM_TASKS];

   sched_result_type pending_picks [$];
   int               error_count;
   bit               req_steady;
   bit               rsp_steady;

   task_ready_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // apply one command to the predicted table and report the pick
   function automatic sched_result_type schedule_after(
      input logic [trs_pkg::CMD_W-1:0]    cmd,
      input logic [trs_pkg::TASK_W-1:0]   tid,
      input logic [trs_pkg::AMOUNT_W-1:0] amt
   );
      sched_result_type               res;
      bit                             in_table;
      int                             bound;
      logic [trs_pkg::DELAY_BITS-1:0] room;
      in_table = int'(tid) < trs_pkg::NUM_TASKS;
      case (cmd)
         trs_pkg::CMD_LOAD: begin
            if (in_table) begin
               task_delay[tid] = '0;
               task_done[tid]  = 1'b0;
            end
         end
         trs_pkg::CMD_DELAY: begin
            if (in_table) begin
               room = DELAY_MAX - task_delay[tid];
               if (trs_pkg::DELAY_BITS'(amt) >= room) begin
                  task_delay[tid] = DELAY_MAX;
               end else begin
                  task_delay[tid] = task_delay[tid] + trs_pkg::DELAY_BITS'(amt);
               end
            end
         end
         trs_pkg::CMD_FINISH: begin
            if (in_table) begin
               task_done[tid] = 1'b1;
            end
         end
         trs_pkg::CMD_RESTART: begin
            for (int k = 0; k < trs_pkg::NUM_TASKS; k++) begin
               task_delay[k] = '0;
               task_done[k]  = 1'b0;
            end
         end
         trs_pkg::CMD_TICK: begin
            for (int k = 0; k < trs_pkg::NUM_TASKS; k++) begin
               if (task_delay[k] != '0) begin
                  task_delay[k] = task_delay[k] - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      // lowest-index task that is runnable
      res.next_task  = '0;
      res.next_valid = 1'b0;
      for (int k = 0; k < trs_pkg::NUM_TASKS; k++) begin
         if (!res.next_valid && !task_done[k] && task_delay[k] == '0) begin
            res.next_task  = trs_pkg::TASK_W'(k);
            res.next_valid = 1'b1;
         end
      end
      // every task below the query bound finished
      bound = in_table ? int'(tid) : trs_pkg::NUM_TASKS;
      res.earlier_finished = 1'b1;
      for (int k = 0; k < bound; k++) begin
         if (!task_done[k]) begin
            res.earlier_finished = 1'b0;
         end
      end
      return res;
   endfunction

   // send one command beat and queue its expected result
   task automatic send_command(
      input logic [trs_pkg::CMD_W-1:0]    cmd,
      input logic [trs_pkg::TASK_W-1:0]   tid,
      input logic [trs_pkg::AMOUNT_W-1:0] amt
   );
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= cmd;
      req_chan.task_id      <= tid;
      req_chan.delay_amount <= amt;
      do @(posedge clock); while (!req_chan.ready);
      pending_picks.push_back(schedule_after(cmd, tid, amt));
      if ($urandom_range(0, 39) == 0) begin
         req_steady = !req_steady;
      end
   endtask

   // edge values of the fields, every command and the odd codes
   task automatic test_directed();
      send_command(trs_pkg::CMD_YIELD, 3'd0, 8'h00);
      send_command(CMD_SPARE_LO, 3'd7, 8'hFF);
      send_command(CMD_SPARE_HI, 3'd3, 8'hAA);
      send_command(trs_pkg::CMD_DELAY, 3'd0, 8'hFF);
      send_command(trs_pkg::CMD_DELAY, 3'd0, 8'h55);
      send_command(trs_pkg::CMD_FINISH, 3'd1, 8'h00);
      send_command(trs_pkg::CMD_TICK, 3'd2, 8'h00);
      send_command(trs_pkg::CMD_FINISH, 3'd0, 8'h00);
      send_command(trs_pkg::CMD_YIELD, 3'd2, 8'h00);
      // finish the rest so that nothing is runnable
      for (int k = 2; k < trs_pkg::NUM_TASKS; k++) begin
         send_command(trs_pkg::CMD_FINISH, trs_pkg::TASK_W'(k), 8'h00);
      end
      send_command(trs_pkg::CMD_YIELD, 3'd7, 8'hFF);
      send_command(trs_pkg::CMD_LOAD, 3'd7, 8'h00);
      send_command(trs_pkg::CMD_DELAY, 3'd7, 8'h01);
      send_command(trs_pkg::CMD_TICK, 3'd7, 8'h00);
      send_command(trs_pkg::CMD_RESTART, 3'd5, 8'hFF);
      send_command(trs_pkg::CMD_DELAY, 3'd3, 8'h00);
      send_command(trs_pkg::CMD_FINISH, 3'd0, 8'h00);
      send_command(trs_pkg::CMD_LOAD, 3'd0, 8'h00);
   endtask

   // push one delay counter into saturation and back
   task automatic test_delay_saturation();
      logic [trs_pkg::TASK_W-1:0] sat_task;
      sat_task = trs_pkg::TASK_W'($urandom_range(0, trs_pkg::NUM_TASKS - 1));
      send_command(trs_pkg::CMD_RESTART, trs_pkg::TASK_W'($urandom_range(0, 7)), 8'h00);
      send_command(trs_pkg::CMD_DELAY, sat_task, 8'd100);
      for (int i = 0; i < 257; i++) begin
         send_command(trs_pkg::CMD_DELAY, sat_task, 8'hFF);
      end
      // zero room left, then room equal to the amount
      send_command(trs_pkg::CMD_DELAY, sat_task, 8'h00);
      send_command(trs_pkg::CMD_TICK, trs_pkg::TASK_W'($urandom_range(0, 7)), 8'h00);
      send_command(trs_pkg::CMD_TICK, trs_pkg::TASK_W'($urandom_range(0, 7)), 8'h00);
      send_command(trs_pkg::CMD_DELAY, sat_task, 8'd2);
      send_command(trs_pkg::CMD_TICK, sat_task, 8'h00);
      send_command(trs_pkg::CMD_DELAY, sat_task, 8'd1);
      send_command(trs_pkg::CMD_LOAD, sat_task, 8'h00);
   endtask

   // weighted command mix that keeps tasks cycling between states
   task automatic test_random_mix(input int count);
      int                           pick;
      logic [trs_pkg::CMD_W-1:0]    cmd;
      logic [trs_pkg::AMOUNT_W-1:0] amt;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         amt  = trs_pkg::AMOUNT_W'($urandom_range(0, 255));
         if (pick < 10) begin
            cmd = trs_pkg::CMD_LOAD;
         end else if (pick < 35) begin
            cmd = trs_pkg::CMD_DELAY;
            if ($urandom_range(0, 9) != 0) begin
               amt = trs_pkg::AMOUNT_W'($urandom_range(0, 6));
            end
         end else if (pick < 50) begin
            cmd = trs_pkg::CMD_FINISH;
         end else if (pick < 60) begin
            cmd = trs_pkg::CMD_YIELD;
         end else if (pick < 63) begin
            cmd = trs_pkg::CMD_RESTART;
         end else if (pick < 93) begin
            cmd = trs_pkg::CMD_TICK;
         end else begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
         end
         send_command(cmd, trs_pkg::TASK_W'($urandom_range(0, 7)), amt);
      end
   endtask

   // result beat checker with random back-pressure
   initial begin : result_monitor
      int               gap;
      sched_result_type want;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = rsp_steady ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         if (pending_picks.size() == 0) begin
            $error("result beat with no command outstanding");
            error_count++;
         end else begin
            want = pending_picks.pop_front();
            if (rsp_chan.next_task !== want.next_task) begin
               $error("next_task: expected %0d, got %0d", want.next_task,
                      rsp_chan.next_task);
               error_count++;
            end
            if (rsp_chan.next_valid !== want.next_valid) begin
               $error("next_valid: expected %0d, got %0d", want.next_valid,
                      rsp_chan.next_valid);
               error_count++;
            end
            if (rsp_chan.earlier_finished !== want.earlier_finished) begin
               $error("earlier_finished: expected %0d, got %0d",
                      want.earlier_finished, rsp_chan.earlier_finished);
               error_count++;
            end
         end
         if ($urandom_range(0, 39) == 0) begin
            rsp_steady = !rsp_steady;
         end
      end
   end

   // watchdog
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // test sequence
   initial begin
      error_count = 0;
      req_steady  = 1'b0;
      rsp_steady  = 1'b0;
      for (int k = 0; k < trs_pkg::NUM_TASKS; k++) begin
         task_delay[k] = '0;
         task_done[k]  = 1'b0;
      end
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.cmd          <= trs_pkg::CMD_YIELD;
      req_chan.task_id      <= '0;
      req_chan.delay_amount <= '0;
      rsp_chan.ready        <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_delay_saturation();
      test_random_mix(1420);

      // let outstanding beats drain
      req_chan.valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/trs_pkg.sv
hdl/trs_req_if.sv
hdl/trs_rsp_if.sv
hdl/trs_table.sv
hdl/trs_ctrl.sv
hdl/task_ready_scheduler.sv
dv/task_ready_scheduler_test.sv
